@@ rtl/core/grp_pkg.sv @@
// ----------------------------------------------------------------------------
// Guillotine packer package
// Shared constants, types and status codes of the rectangle packer.
// ----------------------------------------------------------------------------
package grp_pkg;

	localparam int MAX_FREE_RECTS_DEF = 32;
	localparam int COORD_BITS_DEF     = 16;
	localparam int CFG_BITS           = 12;
	localparam int FIELD_BITS         = 16;
	localparam int CFG_IDX_BITS       = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_KERF   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MARGIN = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROT    = 2'd2;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PLACE = 1'b1;

	typedef enum logic [1:0] {
		ST_PLACED    = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_READY     = 2'd2,
		ST_TOO_SMALL = 2'd3
	} status_t;

endpackage

@@ rtl/core/guillotine_rect_packer_core.sv @@
// A start result is offered right after its input transfer. A placement computes the part area,
// scans all n free rectangles, moves each entry behind the used one up and pushes the right and
// top remainders before it transfers out; a part that does not fit transfers out after the scan.
// One item at a time; the input is ready again in the cycle after the result transfer.
// Reset clears the free count and configuration (rotation allowed); RAM contents stay undefined.
// ----------------------------------------------------------------------------
// Guillotine rectangle packer core
// Best-area-fit placement over an ordered free list held in a RAM.
// ----------------------------------------------------------------------------
module guillotine_rect_packer_core #(
	parameter int MAX_FREE_RECTS = grp_pkg::MAX_FREE_RECTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// item_width, item_height, part_id, instance_id
	input  logic [63:0] s_tdata,
	// command
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pos_x, pos_y, rotated, placed_part_id, placed_instance_id, rect_dropped, zeros
	output logic [71:0] m_tdata,
	// status
	output logic [1:0]  m_tuser
);

	localparam int COORD_BITS = grp_pkg::COORD_BITS_DEF;
	localparam int IW = $clog2(MAX_FREE_RECTS);
	localparam int CW = $clog2(MAX_FREE_RECTS + 1);
	localparam int PW = COORD_BITS + 1;
	localparam int AW = 2 * PW;
	localparam int RW = 4 * COORD_BITS;
	localparam logic [CW-1:0] MAXC = CW'(MAX_FREE_RECTS);

	typedef enum logic [8:0] {
		S_IDLE  = 9'h001,
		S_RD    = 9'h002,
		S_SCAN  = 9'h004,
		S_PICK  = 9'h008,
		S_SHIFT = 9'h010,
		S_PUSHR = 9'h020,
		S_PUSHT = 9'h040,
		S_OUT   = 9'h080,
		S_AREA  = 9'h100
	} fsm_t;

	fsm_t fsm_q;
	logic [11:0] kerf_q, margin_q;
	logic        rot_en_q;
	logic [CW-1:0] cnt_q, idx_q;
	logic [PW-1:0] pw_q, ph_q;
	logic [AW-1:0] parea_q, best_sc_q;
	logic          found_q, best_rot_q;
	logic [IW-1:0] best_q;
	logic [COORD_BITS-1:0] bx_q, by_q, bw_q, bh_q;
	logic [15:0] pid_q, iid_q;
	logic [1:0]  status_q;
	logic        drop_q, rotout_q;
	logic [15:0] px_q, py_q;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	logic [RW-1:0] wdata, rdata;
	logic [IW-1:0] rptr_q;

	grp_ram #(.WIDTH(RW), .DEPTH(MAX_FREE_RECTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [COORD_BITS-1:0] rx, ry, rw, rh;
	assign rx = rdata[COORD_BITS-1:0];
	assign ry = rdata[2*COORD_BITS-1:COORD_BITS];
	assign rw = rdata[3*COORD_BITS-1:2*COORD_BITS];
	assign rh = rdata[4*COORD_BITS-1:3*COORD_BITS];

	// Shared multiplier: part area in S_AREA, entry area in S_SCAN.
	logic [PW-1:0] ma, mb;
	logic [AW-1:0] prod;
	assign ma = (fsm_q == S_AREA) ? pw_q : PW'(rw);
	assign mb = (fsm_q == S_AREA) ? ph_q : PW'(rh);
	assign prod = ma * mb;

	logic [AW-1:0] score;
	logic fit_u, fit_r, better;
	assign score  = prod - parea_q;
	assign fit_u  = (pw_q <= PW'(rw)) && (ph_q <= PW'(rh));
	assign fit_r  = rot_en_q && (ph_q <= PW'(rw)) && (pw_q <= PW'(rh));
	assign better = !found_q || (score < best_sc_q);

	logic [PW-1:0] uw, uh;
	assign uw = best_rot_q ? ph_q : pw_q;
	assign uh = best_rot_q ? pw_q : ph_q;

	logic [16:0] ew, eh;
	assign ew = {1'b0, s_tdata[15:0]} - {4'd0, margin_q, 1'b0};
	assign eh = {1'b0, s_tdata[31:16]} - {4'd0, margin_q, 1'b0};

	assign s_tready = (fsm_q == S_IDLE);
	assign m_tvalid = (fsm_q == S_OUT);
	assign m_tuser  = status_q;
	assign m_tdata  = {6'd0, drop_q, iid_q, pid_q, rotout_q, py_q, px_q};

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = rptr_q;
		unique case (fsm_q)
			S_IDLE: begin
				we = s_tvalid && (s_tuser == grp_pkg::CMD_START) && !ew[16] && !eh[16]
					&& (ew != '0) && (eh != '0);
				wdata = {COORD_BITS'(eh), COORD_BITS'(ew), COORD_BITS'(margin_q),
					COORD_BITS'(margin_q)};
			end
			S_SHIFT: begin
				we = (idx_q + 1'b1 < cnt_q);
				waddr = idx_q[IW-1:0];
				wdata = rdata;
			end
			S_PUSHR: begin
				we = (PW'(bw_q) > uw) && (cnt_q < MAXC);
				waddr = cnt_q[IW-1:0];
				wdata = {bh_q, COORD_BITS'(PW'(bw_q) - uw), by_q, COORD_BITS'(PW'(bx_q) + uw)};
			end
			S_PUSHT: begin
				we = (PW'(bh_q) > uh) && (cnt_q < MAXC);
				waddr = cnt_q[IW-1:0];
				wdata = {COORD_BITS'(PW'(bh_q) - uh), COORD_BITS'(uw),
					COORD_BITS'(PW'(by_q) + uh), bx_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q    <= S_IDLE;
			kerf_q   <= '0;
			margin_q <= '0;
			rot_en_q <= 1'b1;
			cnt_q    <= '0;
			idx_q    <= '0;
			rptr_q   <= '0;
			found_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					grp_pkg::REG_KERF:   kerf_q   <= cfg_wdata;
					grp_pkg::REG_MARGIN: margin_q <= cfg_wdata;
					grp_pkg::REG_ROT:    rot_en_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			unique case (fsm_q)
				S_IDLE: begin
					if (s_tvalid) begin
						pw_q  <= PW'(s_tdata[15:0]) + PW'(kerf_q);
						ph_q  <= PW'(s_tdata[31:16]) + PW'(kerf_q);
						pid_q <= s_tdata[47:32];
						iid_q <= s_tdata[63:48];
						px_q <= '0; py_q <= '0; rotout_q <= 1'b0; drop_q <= 1'b0;
						found_q <= 1'b0;
						idx_q <= '0;
						rptr_q <= '0;
						if (s_tuser == grp_pkg::CMD_START) begin
							pid_q <= '0; iid_q <= '0;
							if (we) begin
								cnt_q <= CW'(1);
								status_q <= grp_pkg::ST_READY;
							end else begin
								cnt_q <= '0;
								status_q <= grp_pkg::ST_TOO_SMALL;
							end
							fsm_q <= S_OUT;
						end else begin
							fsm_q <= S_AREA;
						end
					end
				end
				S_AREA: begin
					parea_q <= prod;
					fsm_q <= S_RD;
				end
				S_RD: begin
					if (idx_q >= cnt_q) begin
						fsm_q <= S_PICK;
					end else begin
						rptr_q <= rptr_q + 1'b1;
						fsm_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if ((fit_u || fit_r) && better) begin
						found_q <= 1'b1;
						best_sc_q <= score;
						best_q <= idx_q[IW-1:0];
						best_rot_q <= !fit_u;
						bx_q <= rx; by_q <= ry; bw_q <= rw; bh_q <= rh;
					end
					idx_q <= idx_q + 1'b1;
					fsm_q <= S_RD;
				end
				S_PICK: begin
					if (!found_q) begin
						status_q <= grp_pkg::ST_NO_FIT;
						fsm_q <= S_OUT;
					end else begin
						status_q <= grp_pkg::ST_PLACED;
						px_q <= bx_q; py_q <= by_q; rotout_q <= best_rot_q;
						idx_q <= CW'(best_q);
						rptr_q <= best_q + 1'b1;
						fsm_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					// RAM read data is registered: found_q alternates a bubble step with a step that copies entry idx+1 to idx.
					if (idx_q + 1'b1 < cnt_q) begin
						if (found_q) begin
							found_q <= 1'b0;
						end else begin
							found_q <= 1'b1;
							idx_q <= idx_q + 1'b1;
							rptr_q <= rptr_q + 1'b1;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
						fsm_q <= S_PUSHR;
					end
				end
				S_PUSHR: begin
					if (PW'(bw_q) > uw) begin
						if (cnt_q < MAXC) cnt_q <= cnt_q + 1'b1;
						else drop_q <= 1'b1;
					end
					fsm_q <= S_PUSHT;
				end
				S_PUSHT: begin
					if (PW'(bh_q) > uh) begin
						if (cnt_q < MAXC) cnt_q <= cnt_q + 1'b1;
						else drop_q <= 1'b1;
					end
					fsm_q <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) fsm_q <= S_IDLE;
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/grp_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module grp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/grp_checker.sv @@
// ----------------------------------------------------------------------------
// Packer port checker
// Checks handshake and result codes seen on the core's ports.
// ----------------------------------------------------------------------------
module grp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic [1:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while a result waits");

	a_start_code: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == grp_pkg::CMD_START) |=>
		m_tvalid && ((m_tuser == grp_pkg::ST_READY) || (m_tuser == grp_pkg::ST_TOO_SMALL)))
		else $error("start transfer gave a wrong status");

	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == grp_pkg::ST_NO_FIT) |-> m_tdata[32:0] == '0)
		else $error("no fit result carries a position");

endmodule

bind guillotine_rect_packer_core grp_checker u_grp_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);

@@ verif/guillotine_rect_packer_core_tb.sv @@
// ----------------------------------------------------------------------------
// Guillotine packer core testbench
// Drives start and place commands with random idling on both streams, keeps
// its own copy of the free list, and checks every result field by field.
// ----------------------------------------------------------------------------
module guillotine_rect_packer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NRECT = grp_pkg::MAX_FREE_RECTS_DEF;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] pid;
		logic [15:0] iid;
	} job_t;

	typedef struct packed {
		grp_pkg::status_t status;
		logic [15:0] px;
		logic [15:0] py;
		logic        rot;
		logic [15:0] pid;
		logic [15:0] iid;
		logic        dropped;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;

	job_t     job_queue[$];
	outcome_t outcome_queue[$];
	int       errors = 0;
	int       sent = 0;
	int       received = 0;
	int       placed_cnt = 0;
	int       nofit_cnt = 0;
	int       drop_cnt = 0;
	bit       quiet = 1'b0;
	bit       in_acc = 1'b0;
	longint   cycles = 0;

	logic [11:0] kerf_q = '0;
	logic [11:0] margin_q = '0;
	logic        rot_q = 1'b1;
	logic [15:0] fx[NRECT], fy[NRECT], fw[NRECT], fh[NRECT];
	int          fcount = 0;

	guillotine_rect_packer_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
		.m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	function automatic bit push_free(longint x, longint y, longint w, longint h);
		if (fcount >= NRECT)
			return 1'b0;
		fx[fcount] = x[15:0];
		fy[fcount] = y[15:0];
		fw[fcount] = w[15:0];
		fh[fcount] = h[15:0];
		fcount++;
		return 1'b1;
	endfunction

	function automatic outcome_t pack_step(job_t j);
		outcome_t o;
		int ew, eh, best, i;
		longint pw, ph, parea, score, best_score, uw, uh, rx, ry, rw, rh;
		bit found, best_rot;
		o = '0;
		if (j.cmd == grp_pkg::CMD_START) begin
			ew = int'(j.w) - 2 * int'(margin_q);
			eh = int'(j.h) - 2 * int'(margin_q);
			fcount = 0;
			if (ew <= 0 || eh <= 0) begin
				o.status = grp_pkg::ST_TOO_SMALL;
			end else begin
				void'(push_free(longint'(margin_q), longint'(margin_q), longint'(ew),
					longint'(eh)));
				o.status = grp_pkg::ST_READY;
			end
			return o;
		end
		o.pid = j.pid;
		o.iid = j.iid;
		pw = longint'(j.w) + longint'(kerf_q);
		ph = longint'(j.h) + longint'(kerf_q);
		parea = pw * ph;
		found = 0;
		best_rot = 0;
		best = 0;
		best_score = 0;
		for (i = 0; i < fcount; i++) begin
			rw = longint'(fw[i]);
			rh = longint'(fh[i]);
			score = rw * rh - parea;
			if (pw <= rw && ph <= rh && (!found || score < best_score)) begin
				found = 1;
				best_score = score;
				best = i;
				best_rot = 0;
			end
			if (rot_q && ph <= rw && pw <= rh && (!found || score < best_score)) begin
				found = 1;
				best_score = score;
				best = i;
				best_rot = 1;
			end
		end
		if (!found) begin
			o.status = grp_pkg::ST_NO_FIT;
			return o;
		end
		rx = longint'(fx[best]);
		ry = longint'(fy[best]);
		rw = longint'(fw[best]);
		rh = longint'(fh[best]);
		uw = best_rot ? ph : pw;
		uh = best_rot ? pw : ph;
		o.status = grp_pkg::ST_PLACED;
		o.px = rx[15:0];
		o.py = ry[15:0];
		o.rot = best_rot;
		for (i = best; i + 1 < fcount; i++) begin
			fx[i] = fx[i+1];
			fy[i] = fy[i+1];
			fw[i] = fw[i+1];
			fh[i] = fh[i+1];
		end
		fcount--;
		if (rw > uw && !push_free(rx + uw, ry, rw - uw, rh))
			o.dropped = 1;
		if (rh > uh && !push_free(rx, ry + uh, uw, rh - uh))
			o.dropped = 1;
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch on result %0d: %s got %0h expected %0h", received, what, got,
			want);
		errors++;
	endtask

	task automatic enqueue_job(job_t j);
		job_queue = {job_queue, j};
	endtask

	always @(posedge clk) begin
		in_acc <= arst_n && s_tvalid && s_tready;
	end

	// Driver: one transfer at a time, random bursts of idle cycles between items.
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && in_acc) begin
				s_tvalid <= 1'b0;
				sent++;
				if (!quiet && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 17);
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (!s_tvalid && job_queue.size() > 0) begin
				s_tuser <= job_queue[0].cmd;
				s_tdata <= {job_queue[0].iid, job_queue[0].pid, job_queue[0].h,
					job_queue[0].w};
				outcome_queue = {outcome_queue, pack_step(job_queue.pop_front())};
				s_tvalid <= 1'b1;
			end
		end
	end

	// Receiver: random stall bursts on the result stream.
	int stall_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 16);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		outcome_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = grp_pkg::status_t'(m_tuser);
			{got.dropped, got.iid, got.pid, got.rot, got.py, got.px} = m_tdata[65:0];
			if (m_tdata[71:66] != '0)
				report_mismatch("pad bits", longint'(m_tdata[71:66]), 64'sd0);
			if (outcome_queue.size() == 0) begin
				report_mismatch("unexpected result", longint'(m_tuser), 64'sd0);
			end else begin
				want = outcome_queue.pop_front();
				if (got.status != want.status)
					report_mismatch("status", longint'(got.status), longint'(want.status));
				if (got.px != want.px)
					report_mismatch("pos_x", longint'(got.px), longint'(want.px));
				if (got.py != want.py)
					report_mismatch("pos_y", longint'(got.py), longint'(want.py));
				if (got.rot != want.rot)
					report_mismatch("rotated", longint'(got.rot), longint'(want.rot));
				if (got.pid != want.pid)
					report_mismatch("part_id", longint'(got.pid), longint'(want.pid));
				if (got.iid != want.iid)
					report_mismatch("instance_id", longint'(got.iid), longint'(want.iid));
				if (got.dropped != want.dropped)
					report_mismatch("rect_dropped", longint'(got.dropped),
						longint'(want.dropped));
				if (want.status == grp_pkg::ST_PLACED) placed_cnt++;
				if (want.status == grp_pkg::ST_NO_FIT) nofit_cnt++;
				if (want.dropped) drop_cnt++;
			end
			received++;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [11:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			grp_pkg::REG_KERF: kerf_q = val;
			grp_pkg::REG_MARGIN: margin_q = val;
			grp_pkg::REG_ROT: rot_q = val[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (job_queue.size() > 0 || s_tvalid || outcome_queue.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic job_t make_job(logic cmd, int w, int h);
		job_t j;
		j.cmd = cmd;
		j.w = 16'(w);
		j.h = 16'(h);
		j.pid = 16'($urandom);
		j.iid = 16'($urandom);
		return j;
	endfunction

	// A sheet followed by parts; with small parts the free list can fill and overflow.
	task automatic queue_sheet(int nparts, int part_max);
		int i;
		enqueue_job(make_job(grp_pkg::CMD_START, $urandom_range(2000, 65535),
			$urandom_range(2000, 65535)));
		for (i = 0; i < nparts; i++) begin
			if ($urandom_range(0, 19) == 0)
				enqueue_job(make_job(1'($urandom), $urandom, $urandom));
			else
				enqueue_job(make_job(grp_pkg::CMD_PLACE, $urandom_range(0, part_max),
					$urandom_range(0, part_max)));
		end
	endtask

	initial begin
		int k, phase;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items with reset settings: rotation, ties, extremes and no-fit.
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 16, 16));
		enqueue_job(make_job(grp_pkg::CMD_START, 0, 0));
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 0, 0));
		enqueue_job(make_job(grp_pkg::CMD_START, 16'hFFFF, 16'hFFFF));
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 16'hFFFF, 16'hFFFF));
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 16'hFFFF, 1));
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 1, 16'hFFFF));
		enqueue_job(make_job(grp_pkg::CMD_START, 1000, 200));
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 100, 900));
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 300, 200));
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 0, 0));
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 2000, 10));
		enqueue_job(make_job(grp_pkg::CMD_START, 500, 500));
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 500, 500));
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 1, 1));
		wait_drained();

		write_reg(grp_pkg::REG_KERF, 12'hFFF);
		write_reg(grp_pkg::REG_MARGIN, 12'hFFF);
		write_reg(grp_pkg::REG_ROT, 12'd0);
		write_reg(REG_NONE, 12'hABC);
		enqueue_job(make_job(grp_pkg::CMD_START, 16380, 16380));
		enqueue_job(make_job(grp_pkg::CMD_START, 16381, 16381));
		enqueue_job(make_job(grp_pkg::CMD_START, 16'hFFFF, 16'hFFFF));
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 16'hFFFF, 16'hFFFF));
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 100, 2000));
		enqueue_job(make_job(grp_pkg::CMD_PLACE, 2000, 100));
		wait_drained();

		for (phase = 0; phase < 8; phase++) begin
			write_reg(grp_pkg::REG_KERF, phase == 0 ? 12'd0 : 12'($urandom_range(0, 64)));
			write_reg(grp_pkg::REG_MARGIN,
				phase == 1 ? 12'd0 : 12'($urandom_range(0, 800)));
			write_reg(grp_pkg::REG_ROT, 12'($urandom));
			if (phase == 7)
				quiet = 1'b1;
			for (k = 0; k < 3; k++)
				queue_sheet(45, phase[0] ? 2000 : 12000);
			wait_drained();
		end

		$display("covered %0d items: %0d placed, %0d no fit, %0d with a dropped remainder",
			sent, placed_cnt, nofit_cnt, drop_cnt);
		$display("register settings swept over kerf, margin and rotation extremes");
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

@@ files.f @@
rtl/core/grp_pkg.sv
rtl/core/grp_ram.sv
rtl/core/guillotine_rect_packer_core.sv
rtl/core/grp_checker.sv
verif/guillotine_rect_packer_core_tb.sv
